[design/abtf_pkg.sv]
// Shared constants, register indexes and helpers of the alpha-beta tracking filter.
`default_nettype none

package abtf_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Gains are Q0.16 with one extra bit so that 1.0 can be held.
    localparam int GAIN_BITS = 16;
    localparam int GAIN_W    = GAIN_BITS + 1;

    localparam logic [GAIN_W-1:0] GAIN_ONE    = GAIN_W'(65536);
    localparam logic [GAIN_W-1:0] ALPHA_RESET = GAIN_W'(32768);
    localparam logic [GAIN_W-1:0] BETA_RESET  = GAIN_W'(6554);

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA         = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_BETA          = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP     = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_INIT_ESTIMATE = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] REG_INIT_RATE     = CFG_INDEX_W'(4);

    // Limit a written gain to 1.0.
    function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] v);
        return (v > GAIN_ONE) ? GAIN_ONE : v;
    endfunction

endpackage

`default_nettype wire

[design/abtf_if.sv]
// Request channels of the alpha-beta tracking filter: measurements in, results out.
`default_nettype none

interface abtf_meas_if
    import abtf_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] measurement;

    modport source (output valid, output measurement, input ready);
    modport sink   (input valid, input measurement, output ready);
endinterface

interface abtf_result_if
    import abtf_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] new_estimate;
    logic signed [VALUE_WIDTH-1:0] new_rate;
    logic signed [VALUE_WIDTH-1:0] residual;

    modport source (output valid, output new_estimate, output new_rate, output residual,
                    input ready);
    modport sink   (input valid, input new_estimate, input new_rate, input residual,
                    output ready);
endinterface

`default_nettype wire

[design/alpha_beta_tracking_filter_unit.sv]
// Top level of the alpha-beta tracking filter: bit-serial multiply, divide and state update.
//
// Usage:
//   meas   : measurement requests (valid/ready), one signed Q.FRAC_BITS sample each.
//   result : one request per measurement carrying new_estimate, new_rate and residual.
//   cfg    : write-only port; cfg_index picks alpha_gain, beta_gain, time_step,
//            initial_estimate or initial_rate. Writing an initial value loads the state.
//            Write only while no measurement is in flight.
// Datapath:
//   A measurement passes through the shift-add multiply of rate by time_step (one bit
//   of time_step per cycle), a 17-step shift-add over the gains, and the restoring
//   divide by time_step (one quotient bit per cycle). A new measurement is accepted
//   only once the previous one has reached the output register.
// Reset:
//   Gains return to 0.5 and 0.1, time_step to 1.0, estimate and rate to zero, and the
//   result channel drops valid. No clearing pass is needed.
// Stall:
//   The result sits in an output register. The next measurement is accepted and worked
//   on while it waits; the state update of that measurement holds until the old
//   result is taken.
`default_nettype none

module alpha_beta_tracking_filter_unit
    import abtf_pkg::*;
#(
    parameter  int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter  int FRAC_BITS   = FRAC_BITS_DEF,
    localparam int CFG_WIDTH   = (VALUE_WIDTH > GAIN_W) ? VALUE_WIDTH : GAIN_W
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_WIDTH-1:0]   cfg_data,
    abtf_meas_if.sink                   meas,
    abtf_result_if.source               result
);

    localparam int W      = VALUE_WIDTH;
    localparam int DT_W   = W - 1;
    localparam int PW     = 2 * W - 1;          // |rate| * time_step
    localparam int GW     = W + GAIN_W;         // |residual| * gain
    localparam int XW     = W + FRAC_BITS + 1;  // dividend after the gain scale
    localparam int SW     = (PW > GW) ? PW : GW;
    localparam int STEPS_MAX = (DT_W > GAIN_W) ? DT_W : GAIN_W;
    localparam int CNT_W  = $clog2(STEPS_MAX);

    localparam logic [DT_W-1:0] DT_ONE   = DT_W'(1) << FRAC_BITS;
    localparam logic [SW-1:0]   MAX_MAG  = SW'({(W-1){1'b1}});
    localparam logic [SW-1:0]   LIM_MAG  = SW'({1'b1, {(W-1){1'b0}}});
    localparam logic [W-1:0]    MAX_POS  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]    MIN_NEG  = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRIFT,
        ST_PREDICT,
        ST_RESID,
        ST_GAIN,
        ST_DIV_START,
        ST_DIVIDE,
        ST_UPDATE
    } state_t;

    // Absolute value; the most negative value maps to 2^(W-1), which fits unsigned.
    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // Apply a sign to a magnitude and clip to the signed range.
    function automatic logic [W-1:0] sat_mag(input logic neg, input logic [SW-1:0] m);
        logic [W-1:0] low;
        low = m[W-1:0];
        if (!neg)
            return (m > MAX_MAG) ? MAX_POS : low;
        return (m > LIM_MAG) ? MIN_NEG : (~low + 1'b1);
    endfunction

    // Saturating signed add or subtract.
    function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b,
                                             input logic sub);
        logic [W:0] s;
        s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
        if (s[W] != s[W-1])
            return s[W] ? MIN_NEG : MAX_POS;
        return s[W-1:0];
    endfunction

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [GAIN_W-1:0]  alpha_reg;
    logic [GAIN_W-1:0]  beta_reg;
    logic [DT_W-1:0]    dt_reg;
    logic [W-1:0]       est_reg;
    logic [W-1:0]       rate_reg;

    logic [W-1:0]       meas_reg;
    logic [W-1:0]       mcand_reg;
    logic               rate_neg_reg;
    logic [PW-1:0]      prod_dt_reg;
    logic [W-1:0]       pred_reg;
    logic [W-1:0]       res_reg;
    logic [GW-1:0]      prod_a_reg;
    logic [GW-1:0]      prod_b_reg;
    logic [DT_W-1:0]    rem_reg;
    logic [DT_W-1:0]    xlo_reg;
    logic [DT_W-1:0]    quo_reg;
    logic               ovf_reg;

    logic               out_valid_reg;
    logic [W-1:0]       out_est_reg;
    logic [W-1:0]       out_rate_reg;
    logic [W-1:0]       out_res_reg;

    // Datapath terms of the current cycle.
    logic [DT_W-1:0]    dt_eff;
    logic [W:0]         drift_top;
    logic [W:0]         alpha_top;
    logic [W:0]         beta_top;
    logic [W-1:0]       drift;
    logic [W-1:0]       res_next;
    logic [XW-1:0]      div_x;
    logic [XW-1:0]      div_hi;
    logic [W:0]         trial;
    logic [W-1:0]       delta;
    logic [W-1:0]       adj;
    logic [W-1:0]       rate_next;
    logic [W-1:0]       est_next;
    logic               out_free;

    // A zero step acts as the smallest step.
    assign dt_eff = (dt_reg == '0) ? DT_W'(1) : dt_reg;

    // Shift-add steps: add the multiplicand when the low multiplier bit is set.
    assign drift_top = {1'b0, prod_dt_reg[PW-1:DT_W]} + (prod_dt_reg[0] ? {1'b0, mcand_reg} : '0);
    assign alpha_top = {1'b0, prod_a_reg[GW-1:GAIN_W]} + (prod_a_reg[0] ? {1'b0, mcand_reg} : '0);
    assign beta_top  = {1'b0, prod_b_reg[GW-1:GAIN_W]} + (prod_b_reg[0] ? {1'b0, mcand_reg} : '0);

    assign drift    = sat_mag(rate_neg_reg, SW'(prod_dt_reg >> FRAC_BITS));
    assign res_next = sat_add(meas_reg, pred_reg, 1'b1);

    // Dividend is (|res|*beta << FRAC_BITS) >> 16. Quotient bits at or above W-1 only
    // mean saturation.
    assign div_x  = XW'({prod_b_reg, {FRAC_BITS{1'b0}}} >> GAIN_BITS);
    assign div_hi = div_x >> DT_W;
    assign trial  = {1'b0, rem_reg, xlo_reg[DT_W-1]} - {2'b00, dt_eff};

    assign delta = ovf_reg ? (res_reg[W-1] ? MIN_NEG : MAX_POS)
                           : sat_mag(res_reg[W-1], SW'(quo_reg));
    assign adj   = sat_mag(res_reg[W-1], SW'(prod_a_reg >> GAIN_BITS));

    assign rate_next = sat_add(rate_reg, delta, 1'b0);
    assign est_next  = sat_add(pred_reg, adj, 1'b0);

    assign out_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            alpha_reg     <= ALPHA_RESET;
            beta_reg      <= BETA_RESET;
            dt_reg        <= DT_ONE;
            est_reg       <= '0;
            rate_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop the result once it is taken, unless a new one is loaded this cycle.
            if (result.ready && !(state_reg == ST_UPDATE && out_free))
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ALPHA:         alpha_reg <= clamp_gain(cfg_data[GAIN_W-1:0]);
                    REG_BETA:          beta_reg  <= clamp_gain(cfg_data[GAIN_W-1:0]);
                    REG_TIME_STEP:     dt_reg    <= cfg_data[DT_W-1:0];
                    REG_INIT_ESTIMATE: est_reg   <= cfg_data[W-1:0];
                    REG_INIT_RATE:     rate_reg  <= cfg_data[W-1:0];
                    default:           ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (meas.valid)
                    begin
                        meas_reg     <= meas.measurement;
                        mcand_reg    <= mag_of(rate_reg);
                        rate_neg_reg <= rate_reg[W-1];
                        prod_dt_reg  <= {{W{1'b0}}, dt_eff};
                        cnt_reg      <= CNT_W'(DT_W - 1);
                        state_reg    <= ST_DRIFT;
                    end
                end

                ST_DRIFT:
                begin
                    prod_dt_reg <= {drift_top, prod_dt_reg[DT_W-1:1]};
                    cnt_reg     <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= ST_PREDICT;
                end

                ST_PREDICT:
                begin
                    pred_reg  <= sat_add(est_reg, drift, 1'b0);
                    state_reg <= ST_RESID;
                end

                ST_RESID:
                begin
                    res_reg    <= res_next;
                    mcand_reg  <= mag_of(res_next);
                    prod_a_reg <= {{W{1'b0}}, alpha_reg};
                    prod_b_reg <= {{W{1'b0}}, beta_reg};
                    cnt_reg    <= CNT_W'(GAIN_W - 1);
                    state_reg  <= ST_GAIN;
                end

                ST_GAIN:
                begin
                    prod_a_reg <= {alpha_top, prod_a_reg[GAIN_W-1:1]};
                    prod_b_reg <= {beta_top, prod_b_reg[GAIN_W-1:1]};
                    cnt_reg    <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= ST_DIV_START;
                end

                ST_DIV_START:
                begin
                    ovf_reg   <= (div_hi >= XW'(dt_eff));
                    rem_reg   <= div_hi[DT_W-1:0];
                    xlo_reg   <= div_x[DT_W-1:0];
                    quo_reg   <= '0;
                    cnt_reg   <= CNT_W'(DT_W - 1);
                    state_reg <= ST_DIVIDE;
                end

                ST_DIVIDE:
                begin
                    // Restoring step: keep the difference when it does not borrow.
                    if (!trial[W])
                        rem_reg <= trial[DT_W-1:0];
                    else
                        rem_reg <= {rem_reg[DT_W-2:0], xlo_reg[DT_W-1]};
                    quo_reg <= {quo_reg[DT_W-2:0], !trial[W]};
                    xlo_reg <= {xlo_reg[DT_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= ST_UPDATE;
                end

                ST_UPDATE:
                begin
                    // Hold until the output register is free, then advance the state.
                    if (out_free)
                    begin
                        rate_reg      <= rate_next;
                        est_reg       <= est_next;
                        out_est_reg   <= est_next;
                        out_rate_reg  <= rate_next;
                        out_res_reg   <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign meas.ready          = (state_reg == ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.new_estimate = out_est_reg;
    assign result.new_rate     = out_rate_reg;
    assign result.residual     = out_res_reg;

endmodule

`default_nettype wire

[design/abtf_checker.sv]
// Port-level checks of the alpha-beta tracking filter and their binding to the top level.
`default_nettype none

module abtf_checker #(
    parameter int W = 32
)(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         meas_valid,
    input wire logic         meas_ready,
    input wire logic         res_valid,
    input wire logic         res_ready,
    input wire logic [W-1:0] new_estimate,
    input wire logic [W-1:0] new_rate,
    input wire logic [W-1:0] residual
);

    // A waiting result stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result request withdrawn while stalled");

    // A waiting result keeps its payload.
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(new_estimate) && $stable(new_rate)
                                    && $stable(residual))
        else $error("result payload changed while stalled");

    // A cycle spent in reset leaves no result offered.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !res_valid)
        else $error("result valid after a reset cycle");

    // One measurement at a time: acceptance closes the input.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        meas_valid && meas_ready |=> !meas_ready)
        else $error("second measurement accepted while busy");

    // The serial datapath cannot produce a result right after acceptance.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        meas_valid && meas_ready |=> !$rose(res_valid))
        else $error("result appeared too soon after a measurement");

endmodule

bind alpha_beta_tracking_filter_unit abtf_checker #(.W(VALUE_WIDTH)) u_abtf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .meas_valid   (meas.valid),
    .meas_ready   (meas.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .new_estimate (result.new_estimate),
    .new_rate     (result.new_rate),
    .residual     (result.residual)
);

`default_nettype wire
